@@ sv/ttc_pkg.sv @@
package ttc_pkg;

  localparam int CNT_W     = 13;
  localparam int DEPTH_W   = 16;
  localparam int NUM_WORDS = 6;

  localparam logic [CNT_W-1:0] MAX_TOKEN_LEN = CNT_W'(4096);
  localparam logic [3:0]       HEX_CAP       = 4'd9;
  localparam logic [3:0]       HEX_LIMIT     = 4'd8;

  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7FFF;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 16'sh8000;

  localparam logic [3:0] KIND_INT    = 4'd0;
  localparam logic [3:0] KIND_FLOAT  = 4'd1;
  localparam logic [3:0] KIND_LIST   = 4'd2;
  localparam logic [3:0] KIND_VOCAB  = 4'd3;
  localparam logic [3:0] KIND_BLOB   = 4'd4;
  localparam logic [3:0] KIND_STRING = 4'd5;
  localparam logic [3:0] KIND_TRUE   = 4'd6;
  localparam logic [3:0] KIND_FALSE  = 4'd7;
  localparam logic [3:0] KIND_NULL   = 4'd8;

  // Word match bits, in table order.
  localparam int W_INF   = 0;
  localparam int W_NINF  = 1;
  localparam int W_NAN   = 2;
  localparam int W_TRUE  = 3;
  localparam int W_FALSE = 4;
  localparam int W_NULL  = 5;

  localparam logic [7:0] WORD_TEXT [NUM_WORDS][8] = '{
    '{"i", "n", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"-", "i", "n", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"n", "a", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [CNT_W-1:0] WORD_LEN [NUM_WORDS] = '{
    CNT_W'(3), CNT_W'(4), CNT_W'(3), CNT_W'(4), CNT_W'(5), CNT_W'(4)
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ttc_in_t;

  typedef struct packed {
    logic [7:0]       char_out;
    logic             keep;
    logic             token_done;
    logic [3:0]       token_kind;
    logic [CNT_W-1:0] token_length;
    logic             line_done;
    logic             complete;
  } ttc_out_t;

  typedef struct packed {
    logic [CNT_W-1:0]     count;
    logic [7:0]           first_char;
    logic                 pre;
    logic                 hex;
    logic [3:0]           hpos;
    logic [1:0]           periods;
    logic [1:0]           signs;
    logic                 looks;
    logic                 frac;
    logic [NUM_WORDS-1:0] words;
  } ttc_tok_t;

  typedef struct packed {
    logic                        esc;
    logic                        begun;
    logic                        quoted;
    logic signed [DEPTH_W-1:0]   round_depth;
    logic signed [DEPTH_W-1:0]   curly_depth;
    ttc_tok_t                    tok;
  } ttc_state_t;

  typedef struct packed {
    ttc_state_t st;
    logic       keep;
    logic       close;
  } ttc_take_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic ttc_tok_t tok_clear();
    ttc_tok_t r;
    r       = '0;
    r.pre   = 1'b1;
    r.looks = 1'b1;
    r.words = '1;
    return r;
  endfunction

  function automatic ttc_state_t state_reset();
    ttc_state_t r;
    r     = '0;
    r.tok = tok_clear();
    return r;
  endfunction

  function automatic ttc_tok_t append_char(ttc_tok_t t, logic [7:0] c);
    ttc_tok_t r;
    logic     allowed;
    r = t;
    if (t.count == '0) begin
      r.first_char = c;
    end
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (!((t.count < WORD_LEN[w]) && (WORD_TEXT[w][t.count[2:0]] == c))) begin
        r.words[w] = 1'b0;
      end
    end
    if (t.count < MAX_TOKEN_LEN) begin
      r.count = t.count + 1'b1;
    end
    if (t.looks) begin
      if (c == ".") begin
        r.frac = 1'b1;
        if (t.periods != 2'd2) begin
          r.periods = t.periods + 1'b1;
        end
        if (r.periods == 2'd2) begin
          r.looks = 1'b0;
        end
      end
      if (!t.hex && (c == "e" || c == "E")) begin
        r.frac = 1'b1;
      end
      if (t.pre && (c == "x" || c == "X")) begin
        r.hex  = 1'b1;
        r.hpos = '0;
      end else begin
        if (t.hex && (t.hpos < HEX_CAP)) begin
          r.hpos = t.hpos + 1'b1;
        end
        if (t.pre && (c == "0" || c == "+" || c == "-")) begin
          if (c != "0") begin
            if (t.signs != 2'd2) begin
              r.signs = t.signs + 1'b1;
            end
            if (r.signs == 2'd2) begin
              r.looks = 1'b0;
            end
          end
        end else begin
          r.pre   = 1'b0;
          allowed = is_digit(c) || (c inside {".", "e", "E", "+", "-"}) ||
                    (t.hex && (c inside {["a":"f"], ["A":"F"]}));
          if (!allowed) begin
            r.looks = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic ttc_take_t take_char(ttc_state_t s, logic [7:0] c);
    ttc_take_t r;
    r.st    = s;
    r.keep  = 1'b0;
    r.close = 1'b0;
    if (s.esc) begin
      r.st.tok = append_char(s.tok, c);
      r.st.esc = 1'b0;
      r.keep   = 1'b1;
    end else if (s.begun || !is_blank(c)) begin
      r.st.begun = 1'b1;
      if (c == "\"") begin
        r.st.quoted = !s.quoted;
      end
      if (!r.st.quoted) begin
        if (c == "(" && s.round_depth != DEPTH_MAX) begin
          r.st.round_depth = s.round_depth + 16'sd1;
        end
        if (c == ")" && s.round_depth != DEPTH_MIN) begin
          r.st.round_depth = s.round_depth - 16'sd1;
        end
        if (c == "{" && s.curly_depth != DEPTH_MAX) begin
          r.st.curly_depth = s.curly_depth + 16'sd1;
        end
        if (c == "}" && s.curly_depth != DEPTH_MIN) begin
          r.st.curly_depth = s.curly_depth - 16'sd1;
        end
      end
      if (c == "\\") begin
        r.st.esc = 1'b1;
        r.st.tok = append_char(s.tok, c);
        r.keep   = 1'b1;
      end else if (!r.st.quoted && (c == "," || is_blank(c)) &&
                   r.st.round_depth == '0 && r.st.curly_depth == '0) begin
        r.close    = 1'b1;
        r.st.tok   = tok_clear();
        r.st.begun = 1'b0;
      end else begin
        r.st.tok = append_char(s.tok, c);
        r.keep   = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

@@ sv/ttc_classify.sv @@
module ttc_classify (
  input  ttc_pkg::ttc_tok_t tok,
  output logic [3:0]        kind
);
  import ttc_pkg::*;

  logic numeric;
  logic num_lead;

  assign numeric  = tok.looks && !(tok.hex && (tok.hpos > HEX_LIMIT));
  assign num_lead = (is_digit(tok.first_char) ||
                     (tok.first_char inside {"+", "-", ".", "i", "n"})) &&
                    (tok.first_char != "." || tok.count > CNT_W'(1));

  always_comb begin
    if (tok.words[W_NULL] && tok.count == CNT_W'(4)) begin
      kind = KIND_NULL;
    end else if ((tok.words[W_INF] && tok.count == CNT_W'(3)) ||
                 (tok.words[W_NINF] && tok.count == CNT_W'(4)) ||
                 (tok.words[W_NAN] && tok.count == CNT_W'(3))) begin
      kind = KIND_FLOAT;
    end else if (numeric && num_lead) begin
      kind = tok.frac ? KIND_FLOAT : KIND_INT;
    end else if (tok.first_char == "(") begin
      kind = KIND_LIST;
    end else if (tok.first_char == "[") begin
      kind = KIND_VOCAB;
    end else if (tok.first_char == "{") begin
      kind = KIND_BLOB;
    end else if (tok.words[W_TRUE] && tok.count == CNT_W'(4)) begin
      kind = KIND_TRUE;
    end else if (tok.words[W_FALSE] && tok.count == CNT_W'(5)) begin
      kind = KIND_FALSE;
    end else begin
      kind = KIND_STRING;
    end
  end

endmodule

@@ sv/ttc_step.sv @@
module ttc_step (
  input  ttc_pkg::ttc_state_t st,
  input  ttc_pkg::ttc_in_t    din,
  output ttc_pkg::ttc_state_t st_next,
  output ttc_pkg::ttc_out_t   res
);
  import ttc_pkg::*;

  ttc_take_t  t1;
  ttc_take_t  t2;
  ttc_tok_t   closed_tok;
  logic       done1;
  logic       done2;
  logic [3:0] kind;

  assign t1    = take_char(st, din.ch);
  assign t2    = take_char(t1.st, " ");
  assign done1 = t1.close && (st.tok.count != '0);
  assign done2 = din.last && t2.close && (t1.st.tok.count != '0);

  // A token closed by the character itself is classified from the state it
  // entered with; one closed by the trailing space uses the updated state.
  assign closed_tok = done1 ? st.tok : t1.st.tok;

  ttc_classify u_classify (
    .tok  (closed_tok),
    .kind (kind)
  );

  always_comb begin
    res.char_out     = din.ch;
    res.keep         = t1.keep;
    res.token_done   = done1 || done2;
    res.token_kind   = (done1 || done2) ? kind : KIND_INT;
    res.token_length = (done1 || done2) ? closed_tok.count : '0;
    res.line_done    = din.last;
    res.complete     = din.last && (t2.st.round_depth == '0) &&
                       (t2.st.curly_depth == '0) && !t2.st.quoted;
    st_next          = din.last ? state_reset() : t1.st;
  end

endmodule

@@ sv/text_list_tokenizer_classifier_unit.sv @@
// Takes one character of a text line per transaction and returns one result
// per character through the input and output registers, one character per
// cycle unless out_stall holds the output; the tokenizer state register is
// read and rewritten in a single cycle, so back-to-back characters never wait
// on each other. A result flags the character that closes a token (or the
// line end) with the token's kind and length; the last character's result
// also reports quote and bracket balance. State then returns to reset.
module text_list_tokenizer_classifier_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ttc_pkg::ttc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ttc_pkg::ttc_out_t out_data
);
  import ttc_pkg::*;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  ttc_in_t    s1_data_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  ttc_out_t   out_data_r;
  ttc_state_t st_r;
  ttc_state_t st_nxt;
  ttc_state_t step_st;
  ttc_out_t   step_res;
  logic       out_adv;
  logic       move;
  logic       accept;

  assign out_adv  = !out_valid_r || !out_stall;
  assign move     = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign accept   = in_valid && !in_stall;

  ttc_step u_step (
    .st      (st_r),
    .din     (s1_data_r),
    .st_next (step_st),
    .res     (step_res)
  );

  always_comb begin
    s1_valid_nxt  = accept ? 1'b1 : (move ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
    st_nxt        = move ? step_st : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= state_reset();
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data;
    end
    if (move) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.token_done |-> out_data_r.token_length != '0)
    else $error("closed token reported with zero length");

  a_complete_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.complete |-> out_data_r.line_done)
    else $error("completeness reported before line end");

  a_keep_or_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.line_done |-> !(out_data_r.keep && out_data_r.token_done))
    else $error("character both kept and closing a token");

  a_line_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    move && s1_data_r.last |=> (st_r.tok.count == '0) && !st_r.begun && !st_r.quoted &&
                               !st_r.esc && (st_r.round_depth == '0) &&
                               (st_r.curly_depth == '0))
    else $error("tokenizer state not cleared after line end");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !move |=> $stable(st_r))
    else $error("tokenizer state changed without a transaction");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ttc_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int NUM_CASES = 28;

  typedef struct {
    string      text;
    logic [7:0] lead_c;
    int         lead_n;
    logic [7:0] mid_c;
    int         mid_n;
    bit         done;
    logic [3:0] kind;
    int         len;
    bit         cpl;
  } line_case_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ttc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ttc_out_t out_data;

  text_list_tokenizer_classifier_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Line state of the tokenizer model.
  bit         esc_open;
  bit         tok_open;
  bit         quoted;
  int         rnd_depth;
  int         crl_depth;
  int         tok_len;
  logic [7:0] tok_first;
  bit         in_pre;
  bit         hex_mode;
  int         hex_run;
  int         dots;
  int         signs;
  bit         num_like;
  bit         frac_mark;
  bit [5:0]   word_hits;

  string word_tab [NUM_WORDS] = '{"inf", "-inf", "nan", "true", "false", "null"};

  ttc_out_t   char_results_q [$];
  ttc_out_t   want_res;
  logic [7:0] line_buf [$];
  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  bit         hold_off = 1'b0;

  int phase_idle [5]  = '{0, 86, 0, 25, 0};
  int phase_stall [5] = '{0, 0, 86, 25, 0};

  line_case_t line_cases [NUM_CASES] = '{
    '{"42",          0, 0, 0, 0, 1, KIND_INT,    2,  1},
    '{"-3.5e2",      0, 0, 0, 0, 1, KIND_FLOAT,  6,  1},
    '{"0XaF",        0, 0, 0, 0, 1, KIND_INT,    4,  1},
    '{"0x12345678",  0, 0, 0, 0, 1, KIND_INT,    10, 1},
    '{"0x123456789", 0, 0, 0, 0, 1, KIND_STRING, 11, 1},
    '{"0xe1",        0, 0, 0, 0, 1, KIND_INT,    4,  1},
    '{"inf",         0, 0, 0, 0, 1, KIND_FLOAT,  3,  1},
    '{"-inf",        0, 0, 0, 0, 1, KIND_FLOAT,  4,  1},
    '{"nan",         0, 0, 0, 0, 1, KIND_FLOAT,  3,  1},
    '{"null",        0, 0, 0, 0, 1, KIND_NULL,   4,  1},
    '{"true",        0, 0, 0, 0, 1, KIND_TRUE,   4,  1},
    '{"false",       0, 0, 0, 0, 1, KIND_FALSE,  5,  1},
    '{"1.2.3",       0, 0, 0, 0, 1, KIND_STRING, 5,  1},
    '{"+-1",         0, 0, 0, 0, 1, KIND_STRING, 3,  1},
    '{".",           0, 0, 0, 0, 1, KIND_STRING, 1,  1},
    '{"(1 2)",       0, 0, 0, 0, 1, KIND_LIST,   5,  1},
    '{"[x]",         0, 0, 0, 0, 1, KIND_VOCAB,  3,  1},
    '{"{a,b}",       0, 0, 0, 0, 1, KIND_BLOB,   5,  1},
    '{"\"a b\"",     0, 0, 0, 0, 1, KIND_STRING, 5,  1},
    '{"a\\,b",       0, 0, 0, 0, 1, KIND_STRING, 4,  1},
    '{"(a",          0, 0, 0, 0, 0, '0,          0,  0},
    '{"\"open",      0, 0, 0, 0, 0, '0,          0,  0},
    '{"ab\\",        0, 0, 0, 0, 0, '0,          0,  1},
    '{")x",          0, 0, 0, 0, 0, '0,          0,  0},
    '{" \t\r",       0, 0, 0, 0, 0, '0,          0,  1},
    '{"a",         "a", 40, 0, 0, 1, KIND_STRING, 41, 1},
    '{" ",         "(", 20, ")", 20, 1, KIND_LIST, 40, 1},
    '{" ",         "}", 3, "{", 3, 1, KIND_STRING, 6, 1}
  };

  function void token_restart();
    tok_len   = 0;
    tok_first = '0;
    in_pre    = 1'b1;
    hex_mode  = 1'b0;
    hex_run   = 0;
    dots      = 0;
    signs     = 0;
    num_like  = 1'b1;
    frac_mark = 1'b0;
    word_hits = '1;
  endfunction

  function void line_restart();
    esc_open  = 1'b0;
    tok_open  = 1'b0;
    quoted    = 1'b0;
    rnd_depth = 0;
    crl_depth = 0;
    token_restart();
  endfunction

  function int depth_step(int d, int delta);
    int r;
    r = d + delta;
    if (r > int'(DEPTH_MAX)) r = int'(DEPTH_MAX);
    if (r < int'(DEPTH_MIN)) r = int'(DEPTH_MIN);
    return r;
  endfunction

  function bit digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function bit blank_byte(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function void token_append(logic [7:0] c);
    int p;
    p = tok_len;
    if (p == 0) tok_first = c;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (p >= word_tab[w].len() || word_tab[w][p] != c) word_hits[w] = 1'b0;
    end
    if (tok_len < int'(MAX_TOKEN_LEN)) tok_len++;
    if (!num_like) return;
    if (c == ".") begin
      frac_mark = 1'b1;
      if (dots < 2) dots++;
      if (dots > 1) num_like = 1'b0;
    end
    if (!hex_mode && (c == "e" || c == "E")) frac_mark = 1'b1;
    if (in_pre && (c == "x" || c == "X")) begin
      hex_mode = 1'b1;
      hex_run  = 0;
      return;
    end
    if (hex_mode && hex_run < int'(HEX_CAP)) hex_run++;
    if (in_pre && (c == "0" || c == "+" || c == "-")) begin
      if (c != "0") begin
        if (signs < 2) signs++;
        if (signs > 1) num_like = 1'b0;
      end
      return;
    end
    in_pre = 1'b0;
    if (!(digit_byte(c) || c == "." || c == "e" || c == "E" || c == "+" || c == "-" ||
          (hex_mode && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))))) begin
      num_like = 1'b0;
    end
  endfunction

  function logic [3:0] token_kind_of();
    bit numeric;
    if (word_hits[W_NULL] && tok_len == 4) return KIND_NULL;
    if ((word_hits[W_INF] && tok_len == 3) || (word_hits[W_NINF] && tok_len == 4) ||
        (word_hits[W_NAN] && tok_len == 3)) begin
      return KIND_FLOAT;
    end
    numeric = num_like && !(hex_mode && hex_run > int'(HEX_LIMIT));
    if (numeric && (digit_byte(tok_first) || tok_first inside {"+", "-", ".", "i", "n"}) &&
        (tok_first != "." || tok_len > 1)) begin
      return frac_mark ? KIND_FLOAT : KIND_INT;
    end
    if (tok_first == "(") return KIND_LIST;
    if (tok_first == "[") return KIND_VOCAB;
    if (tok_first == "{") return KIND_BLOB;
    if (word_hits[W_TRUE] && tok_len == 4) return KIND_TRUE;
    if (word_hits[W_FALSE] && tok_len == 5) return KIND_FALSE;
    return KIND_STRING;
  endfunction

  function bit scan_byte(logic [7:0] c, inout bit done, inout logic [3:0] kind,
                         inout int len);
    if (esc_open) begin
      token_append(c);
      esc_open = 1'b0;
      return 1'b1;
    end
    if (!tok_open && !blank_byte(c)) tok_open = 1'b1;
    if (!tok_open) return 1'b0;
    if (c == "\"") quoted = !quoted;
    if (!quoted) begin
      if (c == "(") rnd_depth = depth_step(rnd_depth, 1);
      if (c == ")") rnd_depth = depth_step(rnd_depth, -1);
      if (c == "{") crl_depth = depth_step(crl_depth, 1);
      if (c == "}") crl_depth = depth_step(crl_depth, -1);
    end
    if (c == "\\") begin
      esc_open = 1'b1;
      token_append(c);
      return 1'b1;
    end
    if (!quoted && (c == "," || blank_byte(c)) && rnd_depth == 0 && crl_depth == 0) begin
      if (tok_len > 0) begin
        done = 1'b1;
        kind = token_kind_of();
        len  = tok_len;
      end
      token_restart();
      tok_open = 1'b0;
      return 1'b0;
    end
    token_append(c);
    return 1'b1;
  endfunction

  function ttc_out_t tokenize_char(logic [7:0] c, logic lst);
    ttc_out_t   r;
    bit         kept;
    bit         done;
    bit         cpl;
    logic [3:0] kind;
    int         len;
    done = 1'b0;
    cpl  = 1'b0;
    kind = '0;
    len  = 0;
    kept = scan_byte(c, done, kind, len);
    if (lst) begin
      void'(scan_byte(" ", done, kind, len));
      cpl = rnd_depth == 0 && crl_depth == 0 && !quoted;
      line_restart();
    end
    r.char_out     = c;
    r.keep         = kept;
    r.token_done   = done;
    r.token_kind   = kind;
    r.token_length = CNT_W'(len);
    r.line_done    = lst;
    r.complete     = cpl;
    return r;
  endfunction

  function void put_byte(logic [7:0] b);
    line_buf = {line_buf, b};
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void add_token(int lvl);
    int    k;
    int    n;
    int    i;
    string w;
    k = $urandom_range(0, 9);
    if (lvl >= 3 && k >= 6 && k <= 7) k = 4;
    case (k)
      0: begin
        if ($urandom_range(0, 2) == 0) put_byte(pick("+-"));
        repeat ($urandom_range(1, 6)) put_byte(pick("0123456789"));
      end
      1: begin
        if ($urandom_range(0, 3) == 0) put_byte(pick("+-"));
        repeat ($urandom_range(0, 3)) put_byte(pick("0123456789"));
        put_byte(".");
        repeat ($urandom_range(0, 3)) put_byte(pick("0123456789"));
        if ($urandom_range(0, 1) == 1) begin
          put_byte(pick("eE"));
          if ($urandom_range(0, 1) == 1) put_byte(pick("+-"));
          repeat ($urandom_range(1, 2)) put_byte(pick("0123456789"));
        end
        if ($urandom_range(0, 7) == 0) put_byte(".");
      end
      2: begin
        put_byte("0");
        put_byte(pick("xX"));
        repeat ($urandom_range(0, 10)) put_byte(pick("0123456789abcdefABCDEF"));
      end
      3: begin
        w = word_tab[$urandom_range(0, NUM_WORDS - 1)];
        n = w.len() - (($urandom_range(0, 4) == 0) ? 1 : 0);
        for (i = 0; i < n; i++) put_byte(w[i]);
        if ($urandom_range(0, 5) == 0) put_byte(pick("sx0."));
      end
      4: begin
        repeat ($urandom_range(1, 8)) put_byte(pick("abcdefinrstuxyzEX_019.+-"));
      end
      5: begin
        put_byte("\"");
        repeat ($urandom_range(0, 6)) begin
          n = $urandom_range(0, 9);
          if (n == 0) begin
            put_byte("\\");
            put_byte(pick("\"\\n"));
          end else if (n == 1) begin
            put_byte(8'($urandom_range(128, 255)));
          end else begin
            put_byte(pick("ab ,\t(){}x1"));
          end
        end
        put_byte("\"");
      end
      6, 7: begin
        put_byte(k == 6 ? "(" : "{");
        repeat ($urandom_range(0, 3)) begin
          add_token(lvl + 1);
          put_byte(pick(" ,\t"));
        end
        put_byte(k == 6 ? ")" : "}");
      end
      8: begin
        put_byte("[");
        repeat ($urandom_range(0, 4)) put_byte(pick("abc12"));
        put_byte("]");
      end
      default: begin
        put_byte("\\");
        put_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) put_byte(pick("abcz9"));
      end
    endcase
  endfunction

  // Mostly well-formed lines; some are raw noise or end on an open bracket,
  // an open quote, a stray closer or a dangling escape.
  function automatic void make_line();
    int sel;
    int n;
    line_buf.delete();
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) put_byte(pick(" \t"));
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if (i > 0) repeat ($urandom_range(1, 2)) put_byte(pick(" \t\r\n,"));
        add_token(0);
      end
      if (sel < 20) begin
        put_byte(pick("({\"\\)}"));
      end else if ($urandom_range(0, 4) == 0) begin
        put_byte(pick(" ,"));
      end
    end
  endfunction

  // One transaction per character; its result is predicted once it is accepted.
  task automatic send_char(logic [7:0] c, logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{ch: c, last: lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    char_results_q = {char_results_q, tokenize_char(c, lst)};
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      send_char(line_buf[i], i == line_buf.size() - 1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (char_results_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (char_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result for char %02h", out_data.char_out);
      end else begin
        want_res = char_results_q.pop_front();
        if (out_data !== want_res) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"Mismatch (char keep done kind len line complete): ",
                      "expected %02h %0b %0b %0d %0d %0b %0b, actual %02h %0b %0b %0d %0d %0b %0b"},
                     want_res.char_out, want_res.keep, want_res.token_done,
                     want_res.token_kind, want_res.token_length, want_res.line_done,
                     want_res.complete, out_data.char_out, out_data.keep,
                     out_data.token_done, out_data.token_kind, out_data.token_length,
                     out_data.line_done, out_data.complete);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    ttc_out_t fix;
    int       sent;
    line_restart();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (line_cases[r]) begin
      line_buf.delete();
      repeat (line_cases[r].lead_n) put_byte(line_cases[r].lead_c);
      repeat (line_cases[r].mid_n) put_byte(line_cases[r].mid_c);
      for (int i = 0; i < line_cases[r].text.len(); i++) put_byte(line_cases[r].text[i]);
      send_line();
      fix = char_results_q[$];
      fix.token_done   = line_cases[r].done;
      fix.token_kind   = line_cases[r].kind;
      fix.token_length = CNT_W'(line_cases[r].len);
      fix.complete     = line_cases[r].cpl;
      char_results_q[$] = fix;
    end
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = phase_idle[ph];
      stall_pct     = phase_stall[ph];
      if (ph == 4) hold_off = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        make_line();
        sent += line_buf.size();
        send_line();
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && char_results_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
